// ===== rtl/fra_pkg.sv =====
// Shared types and constants for the free range allocator.
// Used by fra_ctrl, fra_datapath, free_range_allocator_unit and the dv checker and testbench; no dependencies.
package fra_pkg;

   localparam int DEPTH  = 16;   // table entries
   localparam int SLOT_W = 4;    // table index width
   localparam int CNT_W  = 5;    // entry count, holds DEPTH itself
   localparam int OFS_W  = 24;   // pool offset width
   localparam int LEN_W  = 25;   // byte length width
   localparam int SUM_W  = 26;   // offset plus length
   localparam logic [LEN_W-1:0] POOL_MAX = LEN_W'(1) << OFS_W;

   typedef enum logic [1:0] {
      KIND_ALLOC   = 2'd0,
      KIND_TRIM    = 2'd1,
      KIND_RELEASE = 2'd2,
      KIND_NONE    = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      STAT_OK      = 3'd0,
      STAT_PARTIAL = 3'd1,
      STAT_EMPTY   = 3'd2,
      STAT_OUT     = 3'd3,
      STAT_FULL    = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_ALLOC,
      S_TRIM_APPLY,
      S_REL,
      S_REL_NEXT,
      S_RESP
   } state_type;

   typedef enum logic [4:0] {
      ACT_NONE,
      ACT_LOAD,
      ACT_STEP,
      ACT_ALLOC_FIT,
      ACT_ALLOC_BEST,
      ACT_ALLOC_EMPTY,
      ACT_TRIM_SEEK,
      ACT_TRIM_OUT,
      ACT_TRIM_APPLY,
      ACT_REL_OUT,
      ACT_REL_FRONT_SET,
      ACT_REL_FRONT_MERGE,
      ACT_REL_BACK_MARK,
      ACT_REL_BACK_SET,
      ACT_REL_BACK_MERGE,
      ACT_REL_INSERT,
      ACT_REL_FULL
   } action_type;

   typedef struct packed {
      action_type action;
      logic       cfg_wr;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     at_end;
      logic     fits;
      logic     best_zero;
      logic     slot_bad;
      logic     rel_out;
      logic     rel_zero;
      logic     hit_start;
      logic     hit_end;
      logic     after;
      logic     prev_join;
      logic     full;
   } flags_type;

endpackage

// ===== rtl/fra_ctrl.sv =====
// Controller state machine of the free range allocator.
// Depends on fra_pkg; drives fra_datapath through cmd_type, reads flags_type.
module fra_ctrl
   import fra_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_tvalid,
   output logic      req_tready,
   output logic      rsp_tvalid,
   input  logic      rsp_tready,
   input  logic      csr_valid,
   output logic      csr_ready,
   input  flags_type flags,
   output cmd_type   cmd
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_DECODE;
         end
         S_DECODE: begin
            case (flags.kind)
               KIND_ALLOC:   state_in = S_ALLOC;
               KIND_TRIM:    state_in = flags.slot_bad ? S_RESP : S_TRIM_APPLY;
               KIND_RELEASE: state_in = (flags.rel_out || flags.rel_zero) ? S_RESP : S_REL;
               default:      state_in = S_RESP;
            endcase
         end
         S_ALLOC: begin
            if (flags.at_end || flags.fits) state_in = S_RESP;
         end
         S_TRIM_APPLY: state_in = S_RESP;
         S_REL: begin
            if (flags.at_end || flags.hit_start || flags.after) begin
               state_in = S_RESP;
            end else if (flags.hit_end) begin
               state_in = S_REL_NEXT;
            end
         end
         S_REL_NEXT: state_in = S_RESP;
         S_RESP: begin
            if (rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // commands and handshakes
   always_comb begin
      cmd.action = ACT_NONE;
      cmd.cfg_wr = 1'b0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      csr_ready  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            csr_ready  = 1'b1;
            cmd.cfg_wr = csr_valid;
            if (req_tvalid) cmd.action = ACT_LOAD;
         end
         S_DECODE: begin
            case (flags.kind)
               KIND_TRIM:    cmd.action = flags.slot_bad ? ACT_TRIM_OUT : ACT_TRIM_SEEK;
               KIND_RELEASE: begin
                  if (flags.rel_out) cmd.action = ACT_REL_OUT;
               end
               default:      cmd.action = ACT_NONE;
            endcase
         end
         S_ALLOC: begin
            if (flags.at_end) begin
               cmd.action = flags.best_zero ? ACT_ALLOC_EMPTY : ACT_ALLOC_BEST;
            end else if (flags.fits) begin
               cmd.action = ACT_ALLOC_FIT;
            end else begin
               cmd.action = ACT_STEP;
            end
         end
         S_TRIM_APPLY: cmd.action = ACT_TRIM_APPLY;
         S_REL: begin
            if (flags.at_end || (!flags.hit_start && !flags.hit_end && flags.after)) begin
               cmd.action = flags.full ? ACT_REL_FULL : ACT_REL_INSERT;
            end else if (flags.hit_start) begin
               cmd.action = flags.prev_join ? ACT_REL_FRONT_MERGE : ACT_REL_FRONT_SET;
            end else if (flags.hit_end) begin
               cmd.action = ACT_REL_BACK_MARK;
            end else begin
               cmd.action = ACT_STEP;
            end
         end
         S_REL_NEXT: begin
            cmd.action = (!flags.at_end && flags.hit_start) ? ACT_REL_BACK_MERGE
                                                            : ACT_REL_BACK_SET;
         end
         S_RESP: rsp_tvalid = 1'b1;
         default: cmd.action = ACT_NONE;
      endcase
   end

endmodule

// ===== rtl/fra_datapath.sv =====
// Datapath of the free range allocator: range table, walk pointer, result registers.
// Depends on fra_pkg; commanded by fra_ctrl.
module fra_datapath
   import fra_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output flags_type             flags,
   input  logic [1:0]            req_kind,
   input  logic [LEN_W-1:0]      req_size,
   input  logic [LEN_W-1:0]      req_used,
   input  logic [SLOT_W-1:0]     req_slot,
   input  logic [OFS_W-1:0]      req_rel_ofs,
   input  logic [LEN_W-1:0]      req_rel_len,
   input  logic [LEN_W-1:0]      csr_wdata,
   output logic [OFS_W-1:0]      granted_offset,
   output logic [LEN_W-1:0]      granted_size,
   output logic [SLOT_W-1:0]     granted_slot,
   output logic [2:0]            status
);

   // range table and count
   logic [LEN_W-1:0] start_ff [DEPTH];
   logic [LEN_W-1:0] start_in [DEPTH];
   logic [LEN_W-1:0] end_ff   [DEPTH];
   logic [LEN_W-1:0] end_in   [DEPTH];
   logic [CNT_W-1:0] count_ff, count_in;
   logic [LEN_W-1:0] pool_ff;

   // latched request
   kind_type          kind_ff;
   logic [LEN_W-1:0]  size_ff, used_ff, rel_s_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [SUM_W-1:0]  rel_e_ff;
   logic              rel_zero_ff;

   // walk state
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [LEN_W-1:0]  best_ff, best_start_ff, prev_end_ff;
   logic [SLOT_W-1:0] best_i_ff, ext_ff;

   // results
   logic [OFS_W-1:0]  g_ofs_ff;
   logic [LEN_W-1:0]  g_size_ff;
   logic [SLOT_W-1:0] g_slot_ff;
   status_type        g_stat_ff;

   logic [SLOT_W-1:0] ptr;
   logic [LEN_W-1:0]  rd_start, rd_end, sz, rel_e;
   logic [LEN_W-1:0]  back0, back, trim_start, cfg_val;

   // table control
   logic              wr_s_en, wr_e_en, del_en, ins_en;
   logic [SLOT_W-1:0] wr_idx, del_idx, ins_idx;
   logic [LEN_W-1:0]  wr_s, wr_e;

   assign ptr      = idx_ff[SLOT_W-1:0];
   assign rd_start = start_ff[ptr];
   assign rd_end   = end_ff[ptr];
   assign sz       = rd_end - rd_start;
   assign rel_e    = rel_e_ff[LEN_W-1:0];
   assign cfg_val  = (csr_wdata > POOL_MAX) ? POOL_MAX : csr_wdata;

   // trim: returned tail, clamped at offset zero
   assign back0      = (size_ff > used_ff) ? size_ff - used_ff : '0;
   assign back       = (back0 > rd_start) ? rd_start : back0;
   assign trim_start = rd_start - back;

   // status toward the controller
   always_comb begin
      flags.kind      = kind_ff;
      flags.at_end    = idx_ff >= count_ff;
      flags.fits      = sz >= size_ff;
      flags.best_zero = best_ff == '0;
      flags.slot_bad  = CNT_W'(slot_ff) >= count_ff;
      flags.rel_out   = rel_e_ff > SUM_W'(pool_ff);
      flags.rel_zero  = rel_zero_ff;
      flags.hit_start = SUM_W'(rd_start) == rel_e_ff;
      flags.hit_end   = rd_end == rel_s_ff;
      flags.after     = SUM_W'(rd_start) > rel_e_ff;
      flags.prev_join = (idx_ff != '0) && (prev_end_ff == rel_s_ff);
      flags.full      = count_ff == CNT_W'(DEPTH);
   end

   // decode the action into table operations
   always_comb begin
      wr_s_en = 1'b0;
      wr_e_en = 1'b0;
      del_en  = 1'b0;
      ins_en  = 1'b0;
      wr_idx  = ptr;
      del_idx = ptr;
      ins_idx = ptr;
      wr_s    = rd_start;
      wr_e    = rd_end;
      case (cmd.action)
         ACT_ALLOC_FIT: begin
            wr_s_en = 1'b1;
            wr_s    = rd_start + size_ff;
         end
         ACT_ALLOC_BEST: begin
            wr_s_en = 1'b1;
            wr_idx  = best_i_ff;
            wr_s    = best_start_ff + best_ff;
         end
         ACT_TRIM_APPLY: begin
            if (trim_start == rd_end) begin
               del_en = 1'b1;
            end else begin
               wr_s_en = 1'b1;
               wr_s    = trim_start;
            end
         end
         ACT_REL_FRONT_SET: begin
            wr_s_en = 1'b1;
            wr_s    = rel_s_ff;
         end
         ACT_REL_FRONT_MERGE: begin
            wr_e_en = 1'b1;
            wr_idx  = ptr - 1'b1;
            del_en  = 1'b1;
         end
         ACT_REL_BACK_SET: begin
            wr_e_en = 1'b1;
            wr_idx  = ext_ff;
            wr_e    = rel_e;
         end
         ACT_REL_BACK_MERGE: begin
            wr_e_en = 1'b1;
            wr_idx  = ext_ff;
            del_en  = 1'b1;
         end
         ACT_REL_INSERT: begin
            ins_en = 1'b1;
            wr_s   = rel_s_ff;
            wr_e   = rel_e;
         end
         default: wr_s_en = 1'b0;
      endcase
   end

   // next table contents: shift for delete and insert, then point writes
   always_comb begin
      for (int j = 0; j < DEPTH; j++) begin
         start_in[j] = start_ff[j];
         end_in[j]   = end_ff[j];
         if (del_en && SLOT_W'(j) >= del_idx && j < DEPTH - 1) begin
            start_in[j] = start_ff[(j == DEPTH - 1) ? j : j + 1];
            end_in[j]   = end_ff[(j == DEPTH - 1) ? j : j + 1];
         end
         if (ins_en && SLOT_W'(j) > ins_idx) begin
            start_in[j] = start_ff[(j == 0) ? 0 : j - 1];
            end_in[j]   = end_ff[(j == 0) ? 0 : j - 1];
         end
         if (ins_en && SLOT_W'(j) == ins_idx) begin
            start_in[j] = wr_s;
            end_in[j]   = wr_e;
         end
         if (wr_s_en && SLOT_W'(j) == wr_idx) start_in[j] = wr_s;
         if (wr_e_en && SLOT_W'(j) == wr_idx) end_in[j]   = wr_e;
         if (cmd.cfg_wr && j == 0) begin
            start_in[j] = '0;
            end_in[j]   = cfg_val;
         end
      end
   end

   // next count
   always_comb begin
      count_in = count_ff;
      if (del_en) count_in = count_ff - 1'b1;
      if (ins_en) count_in = count_ff + 1'b1;
      if (cmd.cfg_wr) count_in = (cfg_val == '0) ? '0 : CNT_W'(1);
   end

   // next walk pointer
   always_comb begin
      idx_in = idx_ff;
      case (cmd.action)
         ACT_LOAD:          idx_in = '0;
         ACT_STEP:          idx_in = idx_ff + 1'b1;
         ACT_REL_BACK_MARK: idx_in = idx_ff + 1'b1;
         ACT_TRIM_SEEK:     idx_in = CNT_W'(slot_ff);
         default:           idx_in = idx_ff;
      endcase
   end

   // control state: count and pool size
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pool_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (cmd.cfg_wr) pool_ff <= cfg_val;
      end
   end

   // table entries, no reset
   always_ff @(posedge clock) begin
      for (int j = 0; j < DEPTH; j++) begin
         start_ff[j] <= start_in[j];
         end_ff[j]   <= end_in[j];
      end
   end

   // request latch, walk registers and results
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.action == ACT_LOAD) begin
         kind_ff       <= kind_type'(req_kind);
         size_ff       <= req_size;
         used_ff       <= req_used;
         slot_ff       <= req_slot;
         rel_s_ff      <= LEN_W'(req_rel_ofs);
         rel_e_ff      <= SUM_W'(req_rel_ofs) + SUM_W'(req_rel_len);
         rel_zero_ff   <= req_rel_len == '0;
         best_ff       <= '0;
         best_i_ff     <= '0;
         best_start_ff <= '0;
         prev_end_ff   <= '0;
         g_ofs_ff      <= '0;
         g_size_ff     <= '0;
         g_slot_ff     <= '0;
         g_stat_ff     <= STAT_OK;
      end
      if (cmd.action == ACT_STEP || cmd.action == ACT_REL_BACK_MARK) begin
         prev_end_ff <= rd_end;
         if (sz > best_ff) begin
            best_ff       <= sz;
            best_i_ff     <= ptr;
            best_start_ff <= rd_start;
         end
      end
      if (cmd.action == ACT_REL_BACK_MARK) ext_ff <= ptr;
      case (cmd.action)
         ACT_ALLOC_FIT: begin
            g_ofs_ff  <= rd_start[OFS_W-1:0];
            g_size_ff <= size_ff;
            g_slot_ff <= ptr;
         end
         ACT_ALLOC_BEST: begin
            g_ofs_ff  <= best_start_ff[OFS_W-1:0];
            g_size_ff <= best_ff;
            g_slot_ff <= best_i_ff;
            g_stat_ff <= STAT_PARTIAL;
         end
         ACT_ALLOC_EMPTY: g_stat_ff <= STAT_EMPTY;
         ACT_TRIM_OUT:    g_stat_ff <= STAT_OUT;
         ACT_REL_OUT:     g_stat_ff <= STAT_OUT;
         ACT_REL_FULL:    g_stat_ff <= STAT_FULL;
         default: ;
      endcase
   end

   assign granted_offset = g_ofs_ff;
   assign granted_size   = g_size_ff;
   assign granted_slot   = g_slot_ff;
   assign status         = g_stat_ff;

endmodule

// ===== rtl/free_range_allocator_unit.sv =====
// Top level of the free range allocator: stream ports around controller and datapath.
// Depends on fra_pkg, fra_ctrl and fra_datapath.
//
// Keeps an address-ordered table of up to 16 free byte ranges in one pool.
// req_ channel: one request per handshake; tuser holds the kind (allocate,
// trim, release), tdata the sizes, slot and release block.
// rsp_ channel: exactly one response per request: grant offset, size, slot
// and a status code.
// csr_ channel: a write of pool_size (clamped to 2**24) loads one range
// [0, pool_size); write it only while no request is in flight.
// Requests are handled one at a time. A request is loaded and decoded, then the
// table walk visits one entry per cycle through the single table read port
// (allocate and release walk the table, trim goes straight to its slot), then
// the response register shows the result. The next request is taken only
// after the response has been accepted.
// Reset clears the entry count and pool size; the table is empty until a
// pool_size write. While rsp_tready is low the response holds and no new
// request or configuration write is taken.
module free_range_allocator_unit
   import fra_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [1:0]   req_tuser,   // kind
   // request_size, used_size, slot_index, release_offset, release_length, pad
   input  logic [103:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // granted_offset, granted_size, granted_slot, status
   output logic [55:0]  rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [24:0]  csr_wdata   // pool_size
);

   cmd_type           cmd;
   flags_type         flags;
   logic [OFS_W-1:0]  g_ofs;
   logic [LEN_W-1:0]  g_size;
   logic [SLOT_W-1:0] g_slot;
   logic [2:0]        g_stat;

   fra_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .flags      (flags),
      .cmd        (cmd)
   );

   fra_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .flags          (flags),
      .req_kind       (req_tuser),
      .req_size       (req_tdata[24:0]),
      .req_used       (req_tdata[49:25]),
      .req_slot       (req_tdata[53:50]),
      .req_rel_ofs    (req_tdata[77:54]),
      .req_rel_len    (req_tdata[102:78]),
      .csr_wdata      (csr_wdata),
      .granted_offset (g_ofs),
      .granted_size   (g_size),
      .granted_slot   (g_slot),
      .status         (g_stat)
   );

   // pack the response
   assign rsp_tdata = {g_stat, g_slot, g_size, g_ofs};

endmodule

// ===== dv/free_range_allocator_checker.sv =====
// Checker for the free range allocator: snoops the csr_, req_ and rsp_ channels.
// Predicts each response from its own copy of the range table and compares fields.
// Depends on fra_pkg.
module free_range_allocator_checker
   import fra_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [1:0]   req_tuser,
   input  logic [103:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [55:0]  rsp_tdata,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic [24:0]  csr_wdata,
   output int           error_count,
   output int           pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [2:0]       status;
      logic [SLOT_W-1:0] slot;
      logic [LEN_W-1:0] size;
      logic [OFS_W-1:0] offset;
   } grant_type;

   // local copy of the free range table
   logic [LEN_W-1:0] free_lo [DEPTH];
   logic [LEN_W-1:0] free_hi [DEPTH];
   int               free_count;
   logic [LEN_W-1:0] pool_bytes;
   grant_type        grants_due [$];

   function automatic void remove_range(int i);
      if (i >= free_count) return;
      for (int k = i; k + 1 < free_count; k++) begin
         free_lo[k] = free_lo[k+1];
         free_hi[k] = free_hi[k+1];
      end
      free_count--;
   endfunction

   function automatic bit insert_range(int i, logic [LEN_W-1:0] lo, logic [LEN_W-1:0] hi);
      if (free_count >= DEPTH || i > free_count) return 1'b0;
      for (int k = free_count; k > i; k--) begin
         free_lo[k] = free_lo[k-1];
         free_hi[k] = free_hi[k-1];
      end
      free_lo[i] = lo;
      free_hi[i] = hi;
      free_count++;
      return 1'b1;
   endfunction

   // merge a freed block with its neighbors or insert it in address order
   function automatic status_type free_block(logic [OFS_W-1:0] ofs, logic [LEN_W-1:0] len);
      logic [SUM_W-1:0] e;
      e = SUM_W'(ofs) + SUM_W'(len);
      if (e > SUM_W'(pool_bytes)) return STAT_OUT;
      if (len == 0) return STAT_OK;
      for (int i = 0; i < free_count; i++) begin
         if (SUM_W'(free_lo[i]) == e) begin
            free_lo[i] = LEN_W'(ofs);
            if (i > 0 && free_hi[i-1] == free_lo[i]) begin
               free_hi[i-1] = free_hi[i];
               remove_range(i);
            end
            return STAT_OK;
         end
         if (free_hi[i] == LEN_W'(ofs)) begin
            free_hi[i] = LEN_W'(e);
            if (i + 1 < free_count && free_lo[i+1] == free_hi[i]) begin
               free_hi[i] = free_hi[i+1];
               remove_range(i + 1);
            end
            return STAT_OK;
         end
         if (SUM_W'(free_lo[i]) > e)
            return insert_range(i, LEN_W'(ofs), LEN_W'(e)) ? STAT_OK : STAT_FULL;
      end
      return insert_range(free_count, LEN_W'(ofs), LEN_W'(e)) ? STAT_OK : STAT_FULL;
   endfunction

   function automatic grant_type predict_grant(kind_type kind, logic [103:0] d);
      logic [LEN_W-1:0] req_size, used_size, rel_len, sz, best, back;
      logic [SLOT_W-1:0] slot;
      logic [OFS_W-1:0] rel_ofs;
      int               best_i;
      bit               hit;
      grant_type        g;
      req_size  = d[24:0];
      used_size = d[49:25];
      slot      = d[53:50];
      rel_ofs   = d[77:54];
      rel_len   = d[102:78];
      g         = '0;
      g.status  = STAT_OK;
      best      = '0;
      best_i    = 0;
      hit       = 1'b0;
      case (kind)
         KIND_ALLOC: begin
            for (int i = 0; i < free_count && !hit; i++) begin
               sz = free_hi[i] - free_lo[i];
               if (sz >= req_size) begin
                  g.offset = OFS_W'(free_lo[i]);
                  g.size   = req_size;
                  g.slot   = SLOT_W'(i);
                  free_lo[i] += req_size;
                  hit = 1'b1;
               end else if (sz > best) begin
                  best   = sz;
                  best_i = i;
               end
            end
            // fall back to the largest range when nothing fits
            if (!hit) begin
               if (best == 0) begin
                  g.status = STAT_EMPTY;
               end else begin
                  g.offset = OFS_W'(free_lo[best_i]);
                  g.size   = best;
                  g.slot   = SLOT_W'(best_i);
                  free_lo[best_i] = free_hi[best_i];
                  g.status = STAT_PARTIAL;
               end
            end
         end
         KIND_TRIM: begin
            if (slot >= free_count) begin
               g.status = STAT_OUT;
            end else begin
               back = (req_size > used_size) ? req_size - used_size : '0;
               if (back > free_lo[slot]) back = free_lo[slot];
               free_lo[slot] -= back;
               if (free_lo[slot] == free_hi[slot]) remove_range(slot);
            end
         end
         KIND_RELEASE: g.status = free_block(rel_ofs, rel_len);
         default: ;
      endcase
      return g;
   endfunction

   assign pending = grants_due.size();

   always @(posedge clock) begin
      grant_type want, got;
      if (reset) begin
         free_count  = 0;
         pool_bytes  = '0;
         error_count = 0;
         grants_due.delete();
      end else begin
         // reload the table on a pool size write
         if (csr_valid && csr_ready) begin
            pool_bytes = (csr_wdata > POOL_MAX) ? POOL_MAX : csr_wdata;
            free_count = (pool_bytes == 0) ? 0 : 1;
            free_lo[0] = '0;
            free_hi[0] = pool_bytes;
         end
         if (req_tvalid && req_tready)
            grants_due.push_back(predict_grant(kind_type'(req_tuser), req_tdata));
         // compare each response with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (grants_due.size() == 0) begin
               $error("response with no request pending: %h", rsp_tdata);
               error_count++;
            end else begin
               want = grants_due.pop_front();
               if (got.offset !== want.offset) begin
                  $error("granted_offset: expected %h, got %h", want.offset, got.offset);
                  error_count++;
               end
               if (got.size !== want.size) begin
                  $error("granted_size: expected %h, got %h", want.size, got.size);
                  error_count++;
               end
               if (got.slot !== want.slot) begin
                  $error("granted_slot: expected %0d, got %0d", want.slot, got.slot);
                  error_count++;
               end
               if (got.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  error_count++;
               end
            end
         end
      end
   end

endmodule

// ===== dv/tb_free_range_allocator_unit.sv =====
// Top of the free range allocator testbench: clock, reset, requests and verdict.
// Depends on fra_pkg, free_range_allocator_unit and free_range_allocator_checker.
module tb_free_range_allocator_unit;
   import fra_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 5000;

   typedef struct {
      logic [OFS_W-1:0]  offset;
      logic [LEN_W-1:0]  size;
      logic [SLOT_W-1:0] slot;
   } block_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [1:0]   req_tuser = '0;
   logic [103:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [55:0]  rsp_tdata;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [24:0]  csr_wdata = '0;
   int           error_count, pending;
   int           idle_cycles = 0;
   int           rsp_hold = 0;
   bit           busy_mode = 1'b0;   // no idling on either side
   logic [LEN_W-1:0] pool_now = '0;
   kind_type     kinds_sent [$];
   block_type    held [$];

   always #5 clock = ~clock;

   free_range_allocator_unit i_dut (.*);

   free_range_allocator_checker i_checker (.*);

   // stall the response side randomly after each response, unless busy_mode is set
   always @(posedge clock) begin
      int hold;
      hold = rsp_hold;
      if (rsp_tvalid && rsp_tready) hold = busy_mode ? 0 : $urandom_range(0, 9);
      else if (hold > 0) hold--;
      rsp_hold   <= hold;
      rsp_tready <= !reset && hold == 0;
   end

   // remember granted blocks so later trims and releases are well formed
   always @(posedge clock) begin
      block_type b;
      kind_type  k;
      if (req_tvalid && req_tready) kinds_sent.push_back(kind_type'(req_tuser));
      if (rsp_tvalid && rsp_tready && kinds_sent.size() > 0) begin
         k = kinds_sent.pop_front();
         if (k == KIND_ALLOC && rsp_tdata[55:53] <= STAT_PARTIAL && rsp_tdata[48:24] != 0) begin
            b.offset = rsp_tdata[23:0];
            b.size   = rsp_tdata[48:24];
            b.slot   = rsp_tdata[52:49];
            held.push_back(b);
         end
      end
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic send(kind_type kind, logic [LEN_W-1:0] req_size, logic [LEN_W-1:0] used,
                       logic [SLOT_W-1:0] slot, logic [OFS_W-1:0] rel_ofs,
                       logic [LEN_W-1:0] rel_len);
      int gap;
      gap = busy_mode ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tuser  <= kind;
      req_tdata  <= {1'b0, rel_len, rel_ofs, slot, used, req_size};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   // load a new pool size once the block has gone quiet
   task automatic write_pool(logic [24:0] value);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      held.delete();
      pool_now   = (value > POOL_MAX) ? POOL_MAX : value;
      csr_wdata <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic random_item();
      int        pick, j;
      block_type b;
      logic [LEN_W-1:0] used;
      pick = $urandom_range(0, 99);
      if (pick < 40 || held.size() == 0 && pick < 90) begin
         // allocate: mostly small against the pool, sometimes anything up to it
         if ($urandom_range(0, 7) == 0)
            send(KIND_ALLOC, LEN_W'($urandom_range(0, pool_now)), LEN_W'($urandom),
                 SLOT_W'($urandom), OFS_W'($urandom), LEN_W'($urandom));
         else
            send(KIND_ALLOC, LEN_W'($urandom_range(0, pool_now / 16)), LEN_W'($urandom),
                 SLOT_W'($urandom), OFS_W'($urandom), LEN_W'($urandom));
      end else if (pick < 65) begin
         // trim a grant; the used part stays allocated
         j = $urandom_range(0, held.size() - 1);
         b = held[j];
         used = ($urandom_range(0, 9) == 0) ? b.size + LEN_W'(5)
                                           : LEN_W'($urandom_range(0, b.size));
         send(KIND_TRIM, b.size, used, b.slot, OFS_W'($urandom), LEN_W'($urandom));
         if (used < b.size) begin
            b.size = used;
            held[j] = b;
         end
         if (b.size == 0) held.delete(j);
      end else if (pick < 90) begin
         // release a held block
         j = $urandom_range(0, held.size() - 1);
         b = held[j];
         held.delete(j);
         send(KIND_RELEASE, LEN_W'($urandom), LEN_W'($urandom), SLOT_W'($urandom),
              b.offset, b.size);
      end else begin
         send(kind_type'($urandom_range(0, 3)), LEN_W'($urandom), LEN_W'($urandom),
              SLOT_W'($urandom), OFS_W'($urandom), LEN_W'($urandom));
      end
   endtask

   initial begin
      logic [24:0] pools [5];
      pools = '{25'h0001000, 25'h0000000, 25'h1FFFFFF, 25'h1000000, 25'h0000000};
      pools[4] = 25'($urandom_range(1, 25'h1FFFFFF));
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table after reset
      send(KIND_ALLOC, 25'd0, '0, '0, '0, '0);
      send(KIND_TRIM, 25'd8, 25'd0, 4'd0, '0, '0);
      send(KIND_RELEASE, '0, '0, '0, 24'd0, 25'd0);
      send(KIND_RELEASE, '0, '0, '0, 24'hFFFFFF, 25'h1FFFFFF);
      send(KIND_NONE, 25'h1FFFFFF, 25'h1FFFFFF, 4'hF, 24'hFFFFFF, 25'h1FFFFFF);

      // zero-byte grant, fit, partial, exhausted, trims and releases
      write_pool(25'h1000);
      send(KIND_ALLOC, 25'd0, '0, '0, '0, '0);
      send(KIND_ALLOC, 25'd100, '0, '0, '0, '0);
      send(KIND_ALLOC, 25'h1FFFFFF, '0, '0, '0, '0);
      send(KIND_ALLOC, 25'd10, '0, '0, '0, '0);
      send(KIND_TRIM, 25'h1FFFFFF, 25'd0, 4'd0, '0, '0);
      send(KIND_TRIM, 25'd10, 25'd40, 4'd0, '0, '0);
      send(KIND_TRIM, 25'd10, 25'd0, 4'hF, '0, '0);
      send(KIND_RELEASE, '0, '0, '0, 24'd0, 25'd64);
      send(KIND_RELEASE, '0, '0, '0, 24'd64, 25'd0);
      send(KIND_RELEASE, '0, '0, '0, 24'd0, 25'h1001);

      // fragment the table until a release cannot be recorded
      write_pool(25'h1000);
      busy_mode = 1'b1;
      repeat (36) send(KIND_ALLOC, 25'd16, '0, '0, '0, '0);
      for (int i = 1; i < 36; i += 2)
         send(KIND_RELEASE, '0, '0, '0, OFS_W'(16 * i), 25'd16);
      busy_mode = 1'b0;

      // random phases across pool sizes
      foreach (pools[p]) begin
         write_pool(pools[p]);
         for (int n = 0; n < 116; n++) begin
            if (n % 40 == 0) busy_mode = ($urandom_range(0, 3) == 0);
            random_item();
         end
         busy_mode = 1'b0;
      end
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (error_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== free_range_allocator_unit.f =====
rtl/fra_pkg.sv
rtl/fra_ctrl.sv
rtl/fra_datapath.sv
rtl/free_range_allocator_unit.sv
dv/free_range_allocator_checker.sv
dv/tb_free_range_allocator_unit.sv
